/* rtl/typewriter_text_reveal_defines.svh */
// assertion macros shared by the rtl
`ifndef TYPEWRITER_TEXT_REVEAL_DEFINES_SVH
`define TYPEWRITER_TEXT_REVEAL_DEFINES_SVH

`ifndef SYNTHESIS
`define TWR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in typewriter_text_reveal");
`define TWR_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed in typewriter_text_reveal");
`else
`define TWR_ASSERT(label, clk, rst_n, prop)
`define TWR_ASSERT_NEXT(label, clk, rst_n, cause, effect)
`endif

`endif

/* rtl/twr_pkg.sv */
package twr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int BUF_CAP      = BUFFER_BYTES - 1;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = ADDR_W;
    localparam int CUR_W        = ADDR_W + 1;
    localparam int DELAY_W      = 7;
    localparam int FUNC_W       = 2;
    localparam int BYTE_W       = 8;
    localparam int OUT_W        = 6;

    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

    localparam logic [BYTE_W-1:0]  CODE_SPEED    = 8'h01;
    localparam logic [BYTE_W-1:0]  CODE_FONT     = 8'h02;
    localparam logic [BYTE_W-1:0]  MISSING_PARAM = 8'h02;
    localparam logic [DELAY_W-1:0] RESET_DELAY   = 7'd2;
    localparam int                 CODE_LEN      = 2;

    localparam logic [5:0] SPEED_MASKS [8] = '{
        6'd0, 6'd0, 6'd1, 6'd3, 6'd7, 6'd15, 6'd31, 6'd63
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_SKIP,
        S_CODE,
        S_PARAM,
        S_ADV,
        S_DONE
    } t_state;

    function automatic logic [DELAY_W-1:0] delay_for_param(input logic [BYTE_W-1:0] param);
        logic [2:0] speed;
        speed = param[2:0] - 3'd1;
        if (speed == 3'd0) begin
            return '0;
        end
        return DELAY_W'(SPEED_MASKS[speed]) + DELAY_W'(1);
    endfunction

endpackage

/* rtl/twr_ifs.sv */
interface twr_in_if;
    logic                          valid;
    logic                          ready;
    logic [twr_pkg::FUNC_W-1:0]    func;
    logic [twr_pkg::BYTE_W-1:0]    data_byte;
    logic                          button_pressed;

    modport source (output valid, output func, output data_byte, output button_pressed,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input button_pressed,
                    output ready);
endinterface

interface twr_out_if;
    logic                          valid;
    logic                          ready;
    logic [twr_pkg::OUT_W-1:0]     revealed_count;
    logic [twr_pkg::OUT_W-1:0]     text_length;
    logic                          done_res;
    logic                          byte_dropped;

    modport source (output valid, output revealed_count, output text_length,
                    output done_res, output byte_dropped, input ready);
    modport sink   (input valid, input revealed_count, input text_length,
                    input done_res, input byte_dropped, output ready);
endinterface

interface twr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [twr_pkg::DELAY_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/twr_text_ram.sv */
module twr_text_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/typewriter_text_reveal.sv */
// start, append and unused items go from idle to the done state, which registers the result
// tick: the skip, code and parameter states step over codes at the cursor, the advance state
//   moves it, then the done state registers the result; a fresh tick always runs one code skip
// the next item is accepted only in idle, the cycle after the result is registered
// output stalls hold the result register and keep the item waiting in the done state
// reset (sync) clears length, cursor, timer, fresh/valid flags; both delays to 2; buffer stays
`include "typewriter_text_reveal_defines.svh"

module typewriter_text_reveal (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twr_in_if.sink     i_in,
    twr_out_if.source  o_out,
    twr_cfg_if.sink    i_cfg
);

    twr_pkg::t_state                r_state, n_state;
    logic [twr_pkg::LEN_W-1:0]      r_len, n_len;
    logic [twr_pkg::CUR_W-1:0]      r_cursor, n_cursor;
    logic [twr_pkg::DELAY_W-1:0]    r_delay, n_delay;
    logic [twr_pkg::DELAY_W-1:0]    r_timer, n_timer;
    logic [twr_pkg::DELAY_W-1:0]    r_default;
    logic                           r_fresh, n_fresh;
    logic                           r_skip_fresh, n_skip_fresh;
    logic                           r_button, n_button;
    logic                           r_done, n_done;
    logic                           r_dropped, n_dropped;
    logic                           r_out_valid, n_out_valid;
    logic [twr_pkg::OUT_W-1:0]      r_out_count, n_out_count;
    logic [twr_pkg::OUT_W-1:0]      r_out_len, n_out_len;
    logic                           r_out_done, n_out_done;
    logic                           r_out_dropped, n_out_dropped;

    logic                           in_xfer;
    logic                           buf_full;
    logic                           wr_en;
    logic [twr_pkg::ADDR_W-1:0]     rd_addr;
    logic [twr_pkg::BYTE_W-1:0]     rd_data;
    logic [twr_pkg::CUR_W-1:0]      len_ext;
    logic [twr_pkg::CUR_W-1:0]      cur_p1;
    logic [twr_pkg::CUR_W-1:0]      cur_p2;
    logic [twr_pkg::DELAY_W-1:0]    timer_inc;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == twr_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign buf_full  = (r_len == twr_pkg::LEN_W'(twr_pkg::BUF_CAP));
    assign wr_en     = in_xfer && (i_in.func == twr_pkg::FUNC_APPEND) && !buf_full;
    assign len_ext   = twr_pkg::CUR_W'(r_len);
    assign cur_p1    = r_cursor + twr_pkg::CUR_W'(1);
    assign cur_p2    = r_cursor + twr_pkg::CUR_W'(twr_pkg::CODE_LEN);
    assign timer_inc = r_timer + twr_pkg::DELAY_W'(1);
    assign rd_addr   = (r_state == twr_pkg::S_CODE) ? cur_p1[twr_pkg::ADDR_W-1:0]
                                                    : r_cursor[twr_pkg::ADDR_W-1:0];

    twr_text_ram #(
        .DEPTH (twr_pkg::BUFFER_BYTES),
        .WIDTH (twr_pkg::BYTE_W)
    ) u_text_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_len),
        .i_wr_data (i_in.data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= twr_pkg::S_IDLE;
            r_len        <= '0;
            r_cursor     <= '0;
            r_delay      <= twr_pkg::RESET_DELAY;
            r_timer      <= '0;
            r_default    <= twr_pkg::RESET_DELAY;
            r_fresh      <= 1'b0;
            r_skip_fresh <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_len        <= n_len;
            r_cursor     <= n_cursor;
            r_delay      <= n_delay;
            r_timer      <= n_timer;
            r_fresh      <= n_fresh;
            r_skip_fresh <= n_skip_fresh;
            r_out_valid  <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_default <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_button      <= n_button;
        r_done        <= n_done;
        r_dropped     <= n_dropped;
        r_out_count   <= n_out_count;
        r_out_len     <= n_out_len;
        r_out_done    <= n_out_done;
        r_out_dropped <= n_out_dropped;
    end

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_cursor      = r_cursor;
        n_delay       = r_delay;
        n_timer       = r_timer;
        n_fresh       = r_fresh;
        n_skip_fresh  = r_skip_fresh;
        n_button      = r_button;
        n_done        = r_done;
        n_dropped     = r_dropped;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_count   = r_out_count;
        n_out_len     = r_out_len;
        n_out_done    = r_out_done;
        n_out_dropped = r_out_dropped;

        case (r_state)
            twr_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_done    = (r_cursor >= len_ext);
                    n_dropped = 1'b0;
                    n_state   = twr_pkg::S_DONE;
                    case (i_in.func)
                        twr_pkg::FUNC_START: begin
                            n_len    = '0;
                            n_cursor = '0;
                            n_timer  = '0;
                            n_delay  = r_default;
                            n_fresh  = 1'b1;
                        end
                        twr_pkg::FUNC_APPEND: begin
                            if (buf_full) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_len = r_len + twr_pkg::LEN_W'(1);
                            end
                        end
                        twr_pkg::FUNC_TICK: begin
                            n_button = i_in.button_pressed;
                            if (r_fresh) begin
                                n_skip_fresh = 1'b1;
                                n_state      = twr_pkg::S_SKIP;
                            end else begin
                                n_state = twr_pkg::S_ADV;
                            end
                        end
                        default: begin
                            n_state = twr_pkg::S_DONE;
                        end
                    endcase
                end
            end
            twr_pkg::S_SKIP: begin
                if (r_cursor < len_ext) begin
                    n_state = twr_pkg::S_CODE;
                end else begin
                    n_state = r_skip_fresh ? twr_pkg::S_ADV : twr_pkg::S_DONE;
                end
            end
            twr_pkg::S_CODE: begin
                if (rd_data == twr_pkg::CODE_SPEED) begin
                    if (cur_p1 < len_ext) begin
                        n_state = twr_pkg::S_PARAM;
                    end else begin
                        n_delay  = twr_pkg::delay_for_param(twr_pkg::MISSING_PARAM);
                        n_cursor = cur_p2;
                        n_state  = twr_pkg::S_SKIP;
                    end
                end else if (rd_data == twr_pkg::CODE_FONT) begin
                    n_cursor = cur_p2;
                    n_state  = twr_pkg::S_SKIP;
                end else begin
                    n_state = r_skip_fresh ? twr_pkg::S_ADV : twr_pkg::S_DONE;
                end
            end
            twr_pkg::S_PARAM: begin
                n_delay  = twr_pkg::delay_for_param(rd_data);
                n_cursor = cur_p2;
                n_state  = twr_pkg::S_SKIP;
            end
            twr_pkg::S_ADV: begin
                n_fresh      = 1'b0;
                n_skip_fresh = 1'b0;
                n_done       = (r_cursor >= len_ext);
                n_state      = twr_pkg::S_DONE;
                if (r_cursor < len_ext) begin
                    if (r_button || (r_delay == '0)) begin
                        n_cursor = len_ext;
                    end else if (timer_inc >= r_delay) begin
                        n_timer  = '0;
                        n_cursor = cur_p1;
                        n_state  = twr_pkg::S_SKIP;
                    end else begin
                        n_timer = timer_inc;
                    end
                end
            end
            twr_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_count   = (r_cursor < len_ext) ? twr_pkg::OUT_W'(r_cursor)
                                                         : twr_pkg::OUT_W'(r_len);
                    n_out_len     = twr_pkg::OUT_W'(r_len);
                    n_out_done    = r_done;
                    n_out_dropped = r_dropped;
                    n_state       = twr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = twr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.revealed_count = r_out_count;
    assign o_out.text_length    = r_out_len;
    assign o_out.done_res       = r_out_done;
    assign o_out.byte_dropped   = r_out_dropped;

    `TWR_ASSERT(a_cursor_bound, i_clk, i_rst_n, r_cursor <= (len_ext + twr_pkg::CUR_W'(1)))
    `TWR_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, r_state != twr_pkg::S_IDLE)
    `TWR_ASSERT_NEXT(a_fresh_cleared, i_clk, i_rst_n, r_state == twr_pkg::S_ADV, !r_fresh)
    `TWR_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, o_out.valid && o_out.ready && (r_state != twr_pkg::S_DONE), !o_out.valid)

endmodule

/* tb/sv/reveal_checker.sv */
`timescale 1ns / 1ps

module reveal_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    twr_in_if    i_in,
    twr_out_if   i_out,
    twr_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [twr_pkg::OUT_W-1:0] shown;
        logic [twr_pkg::OUT_W-1:0] length;
        logic                      done;
        logic                      dropped;
    } t_reveal;

    logic [twr_pkg::BYTE_W-1:0]  text_mem [twr_pkg::BUFFER_BYTES];
    logic [twr_pkg::CUR_W-1:0]   held_len;
    logic [twr_pkg::CUR_W-1:0]   cursor;
    logic [twr_pkg::DELAY_W-1:0] cur_delay;
    logic [twr_pkg::DELAY_W-1:0] frame_timer;
    logic [twr_pkg::DELAY_W-1:0] start_delay;
    logic                        fresh;
    t_reveal                     expected_reveals [$];
    int                          fail_total;

    // speed s = param - 1 (mod 8); s = 0 is instant, else 2**(s-1) frames
    function automatic logic [twr_pkg::DELAY_W-1:0] speed_delay(
        input logic [twr_pkg::BYTE_W-1:0] param);
        logic [2:0] speed;
        speed = param[2:0] + 3'd7;
        if (speed == 3'd0) begin
            return '0;
        end
        return twr_pkg::DELAY_W'(1) << (speed - 3'd1);
    endfunction

    task automatic skip_codes();
        logic [twr_pkg::BYTE_W-1:0] code;
        logic [twr_pkg::CUR_W-1:0]  next_pos;
        while (cursor < held_len) begin
            code     = text_mem[cursor[twr_pkg::ADDR_W-1:0]];
            next_pos = cursor + twr_pkg::CUR_W'(1);
            if (code != twr_pkg::CODE_SPEED && code != twr_pkg::CODE_FONT) begin
                break;
            end
            if (code == twr_pkg::CODE_SPEED) begin
                if (next_pos < held_len) begin
                    cur_delay = speed_delay(text_mem[next_pos[twr_pkg::ADDR_W-1:0]]);
                end else begin
                    cur_delay = speed_delay(twr_pkg::MISSING_PARAM);
                end
            end
            cursor = cursor + twr_pkg::CUR_W'(twr_pkg::CODE_LEN);
        end
    endtask

    task automatic predict_reveal(input logic [twr_pkg::FUNC_W-1:0] func,
                                  input logic [twr_pkg::BYTE_W-1:0] data,
                                  input logic button, output t_reveal res);
        logic                      done;
        logic                      dropped;
        logic [twr_pkg::CUR_W-1:0] shown;
        done    = cursor >= held_len;
        dropped = 1'b0;
        case (func)
            twr_pkg::FUNC_START: begin
                held_len    = '0;
                cursor      = '0;
                frame_timer = '0;
                cur_delay   = start_delay;
                fresh       = 1'b1;
            end
            twr_pkg::FUNC_APPEND: begin
                if (held_len < twr_pkg::CUR_W'(twr_pkg::BUF_CAP)) begin
                    text_mem[held_len[twr_pkg::ADDR_W-1:0]] = data;
                    held_len = held_len + twr_pkg::CUR_W'(1);
                end else begin
                    dropped = 1'b1;
                end
            end
            twr_pkg::FUNC_TICK: begin
                if (fresh) begin
                    skip_codes();
                    fresh = 1'b0;
                end
                done = cursor >= held_len;
                if (cursor < held_len) begin
                    if (button || cur_delay == '0) begin
                        cursor = held_len;
                    end else begin
                        frame_timer = frame_timer + twr_pkg::DELAY_W'(1);
                        if (frame_timer >= cur_delay) begin
                            frame_timer = '0;
                            cursor = cursor + twr_pkg::CUR_W'(1);
                            skip_codes();
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        shown       = (cursor < held_len) ? cursor : held_len;
        res.shown   = shown[twr_pkg::OUT_W-1:0];
        res.length  = held_len[twr_pkg::OUT_W-1:0];
        res.done    = done;
        res.dropped = dropped;
    endtask

    always @(posedge i_clk) begin
        t_reveal want;
        t_reveal got;
        if (!i_rst_n) begin
            held_len     = '0;
            cursor       = '0;
            cur_delay    = twr_pkg::RESET_DELAY;
            frame_timer  = '0;
            start_delay  = twr_pkg::RESET_DELAY;
            fresh        = 1'b0;
            fail_total   = 0;
            expected_reveals.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                start_delay = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                predict_reveal(i_in.func, i_in.data_byte, i_in.button_pressed, want);
                expected_reveals = {expected_reveals, want};
            end
            if (i_out.valid && i_out.ready) begin
                got.shown   = i_out.revealed_count;
                got.length  = i_out.text_length;
                got.done    = i_out.done_res;
                got.dropped = i_out.byte_dropped;
                if (expected_reveals.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("unexpected result: shown %0d length %0d done %0b dropped %0b",
                                 got.shown, got.length, got.done, got.dropped);
                    end
                end else begin
                    want = expected_reveals.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("mismatch exp/act: shown %0d/%0d length %0d/%0d %s",
                                     want.shown, got.shown, want.length, got.length,
                                     $sformatf("done %0b/%0b dropped %0b/%0b",
                                               want.done, got.done,
                                               want.dropped, got.dropped));
                        end
                    end
                end
            end
            o_fail_count <= fail_total;
            o_pending    <= expected_reveals.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 500;
    localparam int TAIL_CYCLES  = 16;
    localparam logic [twr_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    int   stall_cycles;
    bit   steady;

    twr_in_if  in_ch ();
    twr_out_if out_ch ();
    twr_cfg_if cfg_ch ();

    typewriter_text_reveal u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    reveal_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 14);
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("typewriter_text_reveal verification failed");
        $finish;
    end

    task automatic push_item(input logic [twr_pkg::FUNC_W-1:0] func,
                             input logic [twr_pkg::BYTE_W-1:0] data,
                             input logic button);
        while (!steady && $urandom_range(0, 99) < 14) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= func;
        in_ch.data_byte      <= data;
        in_ch.button_pressed <= button;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_default_delay(input logic [twr_pkg::DELAY_W-1:0] value);
        wait_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [twr_pkg::BYTE_W-1:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            return twr_pkg::CODE_SPEED;
        end else if (pick < 25) begin
            return twr_pkg::CODE_FONT;
        end else if (pick < 45) begin
            return twr_pkg::BYTE_W'($urandom_range(0, 9));
        end
        return twr_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic run_text();
        int n_bytes;
        int n_frames;
        int pick;
        n_bytes  = ($urandom_range(0, 99) < 8) ? $urandom_range(58, 68) : $urandom_range(0, 10);
        n_frames = $urandom_range(1, 16);
        push_item(twr_pkg::FUNC_START, twr_pkg::BYTE_W'($urandom), 1'($urandom));
        repeat (n_bytes) push_item(twr_pkg::FUNC_APPEND, text_byte(), 1'($urandom));
        repeat (n_frames) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                push_item(twr_pkg::FUNC_APPEND, text_byte(), 1'($urandom));
            end else if (pick < 9) begin
                push_item(FUNC_UNUSED, twr_pkg::BYTE_W'($urandom), 1'($urandom));
            end else begin
                if (pick < 12) begin
                    wait_results();
                end
                push_item(twr_pkg::FUNC_TICK, twr_pkg::BYTE_W'($urandom),
                          $urandom_range(0, 99) < 8);
            end
        end
    endtask

    initial begin
        int                          phase;
        logic [twr_pkg::DELAY_W-1:0] delay;
        i_rst_n              = 1'b0;
        steady               = 1'b0;
        items_sent           = 0;
        in_ch.valid          = 1'b0;
        in_ch.func           = twr_pkg::FUNC_START;
        in_ch.data_byte      = '0;
        in_ch.button_pressed = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty buffer and the unused func code
        push_item(twr_pkg::FUNC_TICK, 8'h00, 1'b0);
        push_item(FUNC_UNUSED, 8'hFF, 1'b1);
        // leading codes skipped on the first frame, instant speed reveals all
        push_item(twr_pkg::FUNC_START, 8'hFF, 1'b1);
        push_item(twr_pkg::FUNC_APPEND, twr_pkg::CODE_SPEED, 1'b0);
        push_item(twr_pkg::FUNC_APPEND, 8'h01, 1'b1);
        push_item(twr_pkg::FUNC_APPEND, twr_pkg::CODE_FONT, 1'b0);
        push_item(twr_pkg::FUNC_APPEND, 8'hFF, 1'b0);
        push_item(twr_pkg::FUNC_APPEND, 8'h00, 1'b0);
        push_item(twr_pkg::FUNC_TICK, 8'hFF, 1'b0);
        push_item(twr_pkg::FUNC_TICK, 8'h00, 1'b0);
        // speed code in the last byte, parameter arrives later
        push_item(twr_pkg::FUNC_START, 8'h00, 1'b0);
        push_item(twr_pkg::FUNC_APPEND, 8'h41, 1'b0);
        push_item(twr_pkg::FUNC_APPEND, twr_pkg::CODE_SPEED, 1'b0);
        push_item(twr_pkg::FUNC_TICK, 8'h00, 1'b0);
        push_item(twr_pkg::FUNC_TICK, 8'h00, 1'b0);
        push_item(twr_pkg::FUNC_APPEND, 8'h07, 1'b0);
        push_item(twr_pkg::FUNC_APPEND, 8'h43, 1'b0);
        push_item(twr_pkg::FUNC_APPEND, 8'h44, 1'b0);
        push_item(twr_pkg::FUNC_TICK, 8'h00, 1'b0);
        push_item(twr_pkg::FUNC_TICK, 8'h00, 1'b1);
        push_item(twr_pkg::FUNC_TICK, 8'h00, 1'b1);

        phase = 0;
        while (items_sent < RANDOM_ITEMS + 21) begin
            case (phase % 6)
                0: delay = 7'd0;
                1: delay = 7'd1;
                2: delay = 7'd64;
                3: delay = twr_pkg::DELAY_W'($urandom_range(0, 64));
                4: delay = twr_pkg::RESET_DELAY;
                default: delay = 7'd3;
            endcase
            write_default_delay(delay);
            steady = (phase == 1);
            repeat ($urandom_range(2, 4)) run_text();
            steady = 1'b0;
            phase++;
        end

        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("typewriter_text_reveal verification clean");
        end else begin
            $display("typewriter_text_reveal verification failed");
        end
        $finish;
    end

endmodule

/* typewriter_text_reveal.f */
+incdir+rtl
rtl/twr_pkg.sv
rtl/twr_ifs.sv
rtl/twr_text_ram.sv
rtl/typewriter_text_reveal.sv
tb/sv/reveal_checker.sv
tb/sv/tb_top.sv
